[src/olir_pkg.sv]
// ----------------------------------------------------------------------------
// olir_pkg: shared types and constants for the ordered list
// Sizes, opcode and status codes, the command broadcast to the cells and the
// word conversions used at the edges of the block.
// ----------------------------------------------------------------------------
package olir_pkg;

	localparam int DEPTH     = 64;
	localparam int WORD_BITS = 32;

	localparam int OPC_W    = 2;
	localparam int INDEX_W  = 7;
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 7;

	// count runs 0..DEPTH; positions and counts share one compare width
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

	localparam int GROUP   = 8;
	localparam int NGROUPS = (DEPTH + GROUP - 1) / GROUP;

	typedef enum logic [OPC_W-1:0] {
		OP_INSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_READ   = 2'd2,
		OP_WRITE  = 2'd3
	} opcode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_BAD_INDEX = 2'd1,
		ST_FULL      = 2'd2
	} status_t;

	typedef logic [WORD_BITS-1:0] word_t;
	typedef logic [CMP_W-1:0]     pos_t;

	typedef struct packed {
		logic    apply;
		opcode_t op;
		pos_t    idx;
		pos_t    count;
		word_t   value;
	} cmd_t;

	// keep the low WORD_BITS bits, sign-extending when the word is wider
	function automatic word_t to_word(input logic [VALUE_W-1:0] v);
		word_t w;
		for (int i = 0; i < WORD_BITS; i++) begin
			w[i] = v[(i < VALUE_W) ? i : VALUE_W - 1];
		end
		return w;
	endfunction

	// sign-extend or truncate a stored word to the result width
	function automatic logic [VALUE_W-1:0] to_out(input word_t w);
		logic [VALUE_W-1:0] r;
		for (int i = 0; i < VALUE_W; i++) begin
			r[i] = w[(i < WORD_BITS) ? i : WORD_BITS - 1];
		end
		return r;
	endfunction

endpackage

[src/olir_cell.sv]
// ----------------------------------------------------------------------------
// olir_cell: one list slot
// Holds one entry and, on each applied command, keeps it, takes the word of
// its lower or upper neighbour, loads the request word or clears.
// ----------------------------------------------------------------------------
module olir_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  olir_pkg::cmd_t      cmd,
	input  olir_pkg::pos_t      pos,
	input  olir_pkg::word_t     lower,
	input  olir_pkg::word_t     upper,
	output olir_pkg::word_t     entry,
	output olir_pkg::word_t     hit
);

	olir_pkg::word_t entry_q;
	olir_pkg::word_t entry_nxt;
	olir_pkg::pos_t  pos_inc;

	assign pos_inc = pos + olir_pkg::pos_t'(1);

	always_comb begin
		entry_nxt = entry_q;
		if (cmd.apply) begin
			case (cmd.op)
				olir_pkg::OP_INSERT: begin
					if (pos == cmd.idx) begin
						entry_nxt = cmd.value;
					end else if (pos > cmd.idx && pos <= cmd.count) begin
						entry_nxt = lower;
					end
				end
				olir_pkg::OP_REMOVE: begin
					// close the gap; the freed top slot clears
					if (pos >= cmd.idx && pos < cmd.count) begin
						entry_nxt = (pos_inc == cmd.count) ? '0 : upper;
					end
				end
				olir_pkg::OP_WRITE: begin
					if (pos == cmd.idx) begin
						entry_nxt = cmd.value;
					end
				end
				default: begin
					entry_nxt = entry_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
		end else begin
			entry_q <= entry_nxt;
		end
	end

	assign entry = entry_q;
	assign hit   = (pos == cmd.idx) ? entry_q : '0;

endmodule

[src/olir_gather.sv]
// ----------------------------------------------------------------------------
// olir_gather: registered merge of one group of cell taps
// ORs the tap words of a group of cells; at most one tap is non-zero.
// ----------------------------------------------------------------------------
module olir_gather (
	input  logic            clk,
	input  logic            en,
	input  olir_pkg::word_t taps [olir_pkg::GROUP],
	output olir_pkg::word_t merged
);

	olir_pkg::word_t merged_s1;
	olir_pkg::word_t merged_c;

	always_comb begin
		merged_c = '0;
		for (int i = 0; i < olir_pkg::GROUP; i++) begin
			merged_c = merged_c | taps[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			merged_s1 <= merged_c;
		end
	end

	assign merged = merged_s1;

endmodule

[src/ordered_list_insert_remove.sv]
// ----------------------------------------------------------------------------
// ordered_list_insert_remove: fixed-capacity ordered list of signed words
// Requests (opcode, index, value) arrive on the req channel and each one gives
// exactly one beat on the rsp channel (result_value, status, count).
// Insert at 0..count shifts later entries up; remove below count shifts them
// down and clears the freed top slot; read returns an entry; overwrite
// replaces one and returns the old word. Bad index gives status 1, insert
// into a full list status 2; an error changes nothing.
// Every slot is a cell in a chain; on a shift the cells in the shifted range
// take their neighbour's word in the same clock. Flow: a request is taken in
// S_IDLE, the cells update and the read tap is gathered in S_EXEC, and the
// response register loads in S_DONE; no new request is taken until the last
// one has left S_DONE. A new request is taken while a response waits; if
// rsp_ready stays low the next response holds in the gather stage until the
// response register frees. Reset empties the list and clears all slots to
// zero.
// ----------------------------------------------------------------------------
module ordered_list_insert_remove (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	output logic                              req_ready,
	input  logic [olir_pkg::OPC_W-1:0]        opcode,
	input  logic [olir_pkg::INDEX_W-1:0]      index,
	input  logic signed [olir_pkg::VALUE_W-1:0] value,
	output logic                              rsp_valid,
	input  logic                              rsp_ready,
	output logic signed [olir_pkg::VALUE_W-1:0] result_value,
	output logic [olir_pkg::STATUS_W-1:0]     status,
	output logic [olir_pkg::COUNT_W-1:0]      count
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_EXEC = 3'b010,
		S_DONE = 3'b100
	} state_t;

	state_t               state_q;
	olir_pkg::opcode_t    op_q;
	olir_pkg::pos_t       idx_q;
	olir_pkg::word_t      value_q;
	olir_pkg::pos_t       count_q;
	olir_pkg::status_t    status_c;
	olir_pkg::cmd_t       cmd;

	olir_pkg::status_t    status_s2;
	logic                 keep_s2;

	logic                            rsp_valid_q;
	logic [olir_pkg::VALUE_W-1:0]    result_q;
	olir_pkg::status_t               status_q;
	logic [olir_pkg::COUNT_W-1:0]    count_out_q;

	olir_pkg::word_t entry_w [olir_pkg::DEPTH];
	olir_pkg::word_t hit_w   [olir_pkg::DEPTH];
	olir_pkg::word_t merged_w [olir_pkg::NGROUPS];
	olir_pkg::word_t gathered;

	// index check first, then the full check for insert
	always_comb begin
		status_c = olir_pkg::ST_OK;
		if (op_q == olir_pkg::OP_INSERT) begin
			if (idx_q > count_q) begin
				status_c = olir_pkg::ST_BAD_INDEX;
			end else if (count_q == olir_pkg::pos_t'(olir_pkg::DEPTH)) begin
				status_c = olir_pkg::ST_FULL;
			end
		end else if (idx_q >= count_q) begin
			status_c = olir_pkg::ST_BAD_INDEX;
		end
	end

	assign cmd.apply = (state_q == S_EXEC) && (status_c == olir_pkg::ST_OK);
	assign cmd.op    = op_q;
	assign cmd.idx   = idx_q;
	assign cmd.count = count_q;
	assign cmd.value = value_q;

	for (genvar g = 0; g < olir_pkg::DEPTH; g++) begin : g_cell
		olir_pkg::word_t lower_w;
		olir_pkg::word_t upper_w;
		if (g == 0) begin : g_bottom
			assign lower_w = '0;
		end else begin : g_lower
			assign lower_w = entry_w[g-1];
		end
		if (g == olir_pkg::DEPTH - 1) begin : g_top
			assign upper_w = '0;
		end else begin : g_upper
			assign upper_w = entry_w[g+1];
		end
		olir_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.cmd    (cmd),
			.pos    (olir_pkg::pos_t'(g)),
			.lower  (lower_w),
			.upper  (upper_w),
			.entry  (entry_w[g]),
			.hit    (hit_w[g])
		);
	end

	for (genvar k = 0; k < olir_pkg::NGROUPS; k++) begin : g_group
		olir_pkg::word_t taps [olir_pkg::GROUP];
		for (genvar j = 0; j < olir_pkg::GROUP; j++) begin : g_tap
			if (k * olir_pkg::GROUP + j < olir_pkg::DEPTH) begin : g_live
				assign taps[j] = hit_w[k * olir_pkg::GROUP + j];
			end else begin : g_pad
				assign taps[j] = '0;
			end
		end
		olir_gather u_gather (
			.clk    (clk),
			.en     (state_q == S_EXEC),
			.taps   (taps),
			.merged (merged_w[k])
		);
	end

	always_comb begin
		gathered = '0;
		for (int k = 0; k < olir_pkg::NGROUPS; k++) begin
			gathered = gathered | merged_w[k];
		end
	end

	assign req_ready = (state_q == S_IDLE);

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			op_q    <= olir_pkg::opcode_t'(opcode);
			idx_q   <= olir_pkg::pos_t'(index);
			value_q <= olir_pkg::to_word(value);
		end
		if (state_q == S_EXEC) begin
			status_s2 <= status_c;
			keep_s2   <= (status_c == olir_pkg::ST_OK) && (op_q != olir_pkg::OP_INSERT);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (state_q == S_DONE && (!rsp_valid_q || rsp_ready)) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (cmd.apply && op_q == olir_pkg::OP_INSERT) begin
						count_q <= count_q + olir_pkg::pos_t'(1);
					end else if (cmd.apply && op_q == olir_pkg::OP_REMOVE) begin
						count_q <= count_q - olir_pkg::pos_t'(1);
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					// hold until the response register is free
					if (!rsp_valid_q || rsp_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && (!rsp_valid_q || rsp_ready)) begin
			result_q    <= keep_s2 ? olir_pkg::to_out(gathered) : '0;
			status_q    <= status_s2;
			count_out_q <= olir_pkg::COUNT_W'(count_q);
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign result_value = result_q;
	assign status       = status_q;
	assign count        = count_out_q;

`ifndef SYNTH
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= olir_pkg::pos_t'(olir_pkg::DEPTH))
		else $error("entry count above capacity");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC && cmd.apply && op_q == olir_pkg::OP_INSERT)
		|=> count_q == olir_pkg::pos_t'($past(count_q) + olir_pkg::pos_t'(1)))
		else $error("insert did not grow the list by one");

	a_error_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC && status_c != olir_pkg::ST_OK) |=> $stable(count_q))
		else $error("failed request changed the count");

	a_full_at_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && status_s2 == olir_pkg::ST_FULL)
		|-> count_q == olir_pkg::pos_t'(olir_pkg::DEPTH))
		else $error("full status with spare capacity");
`endif

endmodule

[bench/ordered_list_insert_remove_tb.sv]
// ----------------------------------------------------------------------------
// ordered_list_insert_remove_tb: self-checking bench for the ordered list
// Drives requests on the req channel and checks each rsp beat against a
// shadow copy of the list kept in the bench. A short table covers the empty
// list, the word extremes, every opcode and the bad index cases. Phases of
// random traffic follow, shaped to fill, drain and churn the list, with
// random gaps on both channels, a long response hold-off and full drains.
// ----------------------------------------------------------------------------
module ordered_list_insert_remove_tb;

	typedef struct packed {
		logic [olir_pkg::VALUE_W-1:0] value;
		olir_pkg::status_t            st;
		logic [olir_pkg::COUNT_W-1:0] cnt;
	} list_result_t;

	typedef struct packed {
		olir_pkg::opcode_t            op;
		logic [olir_pkg::INDEX_W-1:0] idx;
		logic [olir_pkg::VALUE_W-1:0] val;
		logic                         pinned;
		list_result_t                 want;
	} stim_row_t;

	typedef enum int {PH_GROW, PH_SHRINK, PH_MIXED, PH_NOISE} phase_kind_t;

	localparam int N_ROWS = 25;
	localparam int RANDOM_ITEMS = 1000;
	localparam list_result_t BAD0 = '{32'h0, olir_pkg::ST_BAD_INDEX, 7'd0};

	logic                                clk = 1'b0;
	logic                                arst_n;
	logic                                req_valid;
	logic                                req_ready;
	logic [olir_pkg::OPC_W-1:0]          opcode;
	logic [olir_pkg::INDEX_W-1:0]        index;
	logic signed [olir_pkg::VALUE_W-1:0] value;
	logic                                rsp_valid;
	logic                                rsp_ready;
	logic signed [olir_pkg::VALUE_W-1:0] result_value;
	logic [olir_pkg::STATUS_W-1:0]       status;
	logic [olir_pkg::COUNT_W-1:0]        count;

	// shadow of the list contents, updated on every accepted request
	olir_pkg::word_t list_words [olir_pkg::DEPTH];
	int              list_len;
	list_result_t    pending_results [$];
	int              error_count;

	// set by the sender alongside each offered request
	logic         pin_set;
	list_result_t pin_result;

	logic         no_idle;
	logic         hold_off_request;

	stim_row_t directed_rows [N_ROWS] = '{
		'{olir_pkg::OP_READ, 7'd0, 32'h0000_0000, 1'b1, BAD0},
		'{olir_pkg::OP_REMOVE, 7'd0, 32'h0000_0000, 1'b1, BAD0},
		'{olir_pkg::OP_WRITE, 7'd0, 32'h7FFF_FFFF, 1'b1, BAD0},
		'{olir_pkg::OP_INSERT, 7'd1, 32'h1234_5678, 1'b1, BAD0},
		'{olir_pkg::OP_INSERT, 7'd64, 32'hFFFF_FFFF, 1'b1, BAD0},
		'{olir_pkg::OP_INSERT, 7'd0, 32'h8000_0000, 1'b1, '{32'h0, olir_pkg::ST_OK, 7'd1}},
		'{olir_pkg::OP_INSERT, 7'd1, 32'h7FFF_FFFF, 1'b1, '{32'h0, olir_pkg::ST_OK, 7'd2}},
		'{olir_pkg::OP_INSERT, 7'd0, 32'hFFFF_FFFF, 1'b1, '{32'h0, olir_pkg::ST_OK, 7'd3}},
		'{olir_pkg::OP_INSERT, 7'd1, 32'h0000_0001, 1'b0, '0},
		'{olir_pkg::OP_READ, 7'd0, 32'h5555_5555, 1'b0, '0},
		'{olir_pkg::OP_READ, 7'd3, 32'hAAAA_AAAA, 1'b0, '0},
		'{olir_pkg::OP_READ, 7'd4, 32'h0, 1'b1, '{32'h0, olir_pkg::ST_BAD_INDEX, 7'd4}},
		'{olir_pkg::OP_READ, 7'd64, 32'h0, 1'b1, '{32'h0, olir_pkg::ST_BAD_INDEX, 7'd4}},
		'{olir_pkg::OP_WRITE, 7'd2, 32'h0000_0000, 1'b0, '0},
		'{olir_pkg::OP_INSERT, 7'd4, 32'hA5A5_A5A5, 1'b1, '{32'h0, olir_pkg::ST_OK, 7'd5}},
		'{olir_pkg::OP_INSERT, 7'd6, 32'h0F0F_0F0F, 1'b1,
			'{32'h0, olir_pkg::ST_BAD_INDEX, 7'd5}},
		'{olir_pkg::OP_REMOVE, 7'd0, 32'hFFFF_FFFF, 1'b0, '0},
		'{olir_pkg::OP_REMOVE, 7'd3, 32'h0000_0000, 1'b0, '0},
		'{olir_pkg::OP_REMOVE, 7'd3, 32'h0, 1'b1, '{32'h0, olir_pkg::ST_BAD_INDEX, 7'd3}},
		'{olir_pkg::OP_WRITE, 7'd3, 32'h8000_0000, 1'b1,
			'{32'h0, olir_pkg::ST_BAD_INDEX, 7'd3}},
		'{olir_pkg::OP_READ, 7'd1, 32'h0000_0000, 1'b0, '0},
		'{olir_pkg::OP_REMOVE, 7'd0, 32'h0000_0000, 1'b0, '0},
		'{olir_pkg::OP_REMOVE, 7'd0, 32'h0000_0000, 1'b0, '0},
		'{olir_pkg::OP_REMOVE, 7'd0, 32'h0000_0000, 1'b0, '0},
		'{olir_pkg::OP_REMOVE, 7'd0, 32'h0000_0000, 1'b1, BAD0}
	};

	ordered_list_insert_remove i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_ready    (req_ready),
		.opcode       (opcode),
		.index        (index),
		.value        (value),
		.rsp_valid    (rsp_valid),
		.rsp_ready    (rsp_ready),
		.result_value (result_value),
		.status       (status),
		.count        (count)
	);

	always #5 clk = ~clk;

	// apply one request to the shadow list and return the result it gives
	function automatic list_result_t list_apply(olir_pkg::opcode_t op,
			logic [olir_pkg::INDEX_W-1:0] idx, logic [olir_pkg::VALUE_W-1:0] val);
		list_result_t    r;
		olir_pkg::word_t w;
		r.value = '0;
		r.st    = olir_pkg::ST_OK;
		w       = olir_pkg::WORD_BITS'($signed(val));
		case (op)
			olir_pkg::OP_INSERT: begin
				if (idx > list_len) begin
					r.st = olir_pkg::ST_BAD_INDEX;
				end else if (list_len >= olir_pkg::DEPTH) begin
					r.st = olir_pkg::ST_FULL;
				end else begin
					for (int i = list_len; i > idx; i--) list_words[i] = list_words[i-1];
					list_words[idx] = w;
					list_len++;
				end
			end
			olir_pkg::OP_REMOVE: begin
				if (idx >= list_len) begin
					r.st = olir_pkg::ST_BAD_INDEX;
				end else begin
					r.value = olir_pkg::VALUE_W'($signed(list_words[idx]));
					for (int i = idx + 1; i < list_len; i++) list_words[i-1] = list_words[i];
					list_words[list_len-1] = '0;
					list_len--;
				end
			end
			olir_pkg::OP_READ: begin
				if (idx >= list_len) r.st = olir_pkg::ST_BAD_INDEX;
				else r.value = olir_pkg::VALUE_W'($signed(list_words[idx]));
			end
			default: begin
				if (idx >= list_len) begin
					r.st = olir_pkg::ST_BAD_INDEX;
				end else begin
					r.value = olir_pkg::VALUE_W'($signed(list_words[idx]));
					list_words[idx] = w;
				end
			end
		endcase
		r.cnt = olir_pkg::COUNT_W'(list_len);
		return r;
	endfunction

	function automatic logic [olir_pkg::VALUE_W-1:0] pick_word();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h0000_0000;
			3: return 32'hFFFF_FFFF;
			default: return $urandom();
		endcase
	endfunction

	// mostly legal positions, front and back often; stray ones span the range
	function automatic logic [olir_pkg::INDEX_W-1:0] pick_index(olir_pkg::opcode_t op,
			bit stray);
		int hi;
		hi = (op == olir_pkg::OP_INSERT) ? list_len : list_len - 1;
		if (stray || hi < 0) return olir_pkg::INDEX_W'($urandom_range(0, olir_pkg::DEPTH));
		case ($urandom_range(0, 5))
			0: return '0;
			1: return olir_pkg::INDEX_W'(hi);
			default: return olir_pkg::INDEX_W'($urandom_range(0, hi));
		endcase
	endfunction

	function automatic olir_pkg::opcode_t pick_opcode(phase_kind_t kind);
		int r;
		r = $urandom_range(0, 99);
		case (kind)
			PH_GROW:   return (r < 85) ? olir_pkg::OP_INSERT : (r < 92) ? olir_pkg::OP_REMOVE :
				(r < 96) ? olir_pkg::OP_READ : olir_pkg::OP_WRITE;
			PH_SHRINK: return (r < 15) ? olir_pkg::OP_INSERT : (r < 75) ? olir_pkg::OP_REMOVE :
				(r < 88) ? olir_pkg::OP_READ : olir_pkg::OP_WRITE;
			PH_MIXED:  return (r < 30) ? olir_pkg::OP_INSERT : (r < 55) ? olir_pkg::OP_REMOVE :
				(r < 80) ? olir_pkg::OP_READ : olir_pkg::OP_WRITE;
			default:   return olir_pkg::opcode_t'(r % 4);
		endcase
	endfunction

	// called at a falling edge; returns at the falling edge after the beat
	task automatic send_request(olir_pkg::opcode_t op, logic [olir_pkg::INDEX_W-1:0] idx,
			logic [olir_pkg::VALUE_W-1:0] val);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_valid <= 1'b1;
		opcode    <= op;
		index     <= idx;
		value     <= val;
		do @(posedge clk); while (!req_ready);
		@(negedge clk);
	endtask

	// drop valid and hold until every outstanding beat has come back
	task automatic drain_responses();
		req_valid <= 1'b0;
		@(negedge clk);
		while (pending_results.size() != 0) @(negedge clk);
	endtask

	always @(posedge clk) begin : scoreboard
		list_result_t predicted;
		list_result_t want;
		if (arst_n) begin
			if (req_valid && req_ready) begin
				predicted = list_apply(olir_pkg::opcode_t'(opcode), index, value);
				pending_results.push_back(pin_set ? pin_result : predicted);
			end
			if (rsp_valid && rsp_ready) begin
				if (pending_results.size() == 0) begin
					$error("unexpected response: value %h status %0d count %0d",
						result_value, status, count);
					error_count++;
				end else begin
					want = pending_results.pop_front();
					if (result_value !== want.value) begin
						$error("result_value mismatch: expected %h, got %h",
							want.value, result_value);
						error_count++;
					end
					if (status !== want.st) begin
						$error("status mismatch: expected %0d, got %0d", want.st, status);
						error_count++;
					end
					if (count !== want.cnt) begin
						$error("count mismatch: expected %0d, got %0d", want.cnt, count);
						error_count++;
					end
				end
			end
		end
	end

	// response side: random stall before each beat, one long hold-off on request
	initial begin
		int stall;
		rsp_ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (hold_off_request) begin
				hold_off_request = 1'b0;
				rsp_ready <= 1'b0;
				repeat (150) @(negedge clk);
			end
			stall = no_idle ? 0 : $urandom_range(0, 13);
			if (stall > 0) begin
				rsp_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			rsp_ready <= 1'b1;
			do @(posedge clk); while (!rsp_valid);
			@(negedge clk);
		end
	end

	initial begin
		phase_kind_t                  kind;
		olir_pkg::opcode_t            op;
		logic [olir_pkg::INDEX_W-1:0] idx;
		int                           phase_len;
		int                           phase_no;
		int                           random_sent;
		bit                           stray;
		arst_n           = 1'b0;
		req_valid        = 1'b0;
		opcode           = olir_pkg::OP_READ;
		index            = '0;
		value            = '0;
		pin_set          = 1'b0;
		pin_result       = '0;
		no_idle          = 1'b0;
		hold_off_request = 1'b0;
		error_count      = 0;
		list_len         = 0;
		for (int i = 0; i < olir_pkg::DEPTH; i++) list_words[i] = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[r]) begin
			pin_set    = directed_rows[r].pinned;
			pin_result = directed_rows[r].want;
			send_request(directed_rows[r].op, directed_rows[r].idx, directed_rows[r].val);
		end
		pin_set = 1'b0;
		drain_responses();

		phase_no    = 0;
		random_sent = 0;
		while (random_sent < RANDOM_ITEMS) begin
			// open with a long fill so the full list is reached early
			if (phase_no == 0) begin
				kind             = PH_GROW;
				phase_len        = 140;
				hold_off_request = 1'b1;
			end else begin
				kind      = phase_kind_t'($urandom_range(0, 3));
				phase_len = $urandom_range(20, 90);
			end
			no_idle = (phase_no % 4 == 2);
			for (int n = 0; n < phase_len; n++) begin
				op    = pick_opcode(kind);
				stray = (kind == PH_NOISE) || ($urandom_range(0, 99) < 8);
				idx   = pick_index(op, stray);
				send_request(op, idx, pick_word());
				random_sent++;
			end
			if (phase_no == 1 || $urandom_range(0, 2) == 0) drain_responses();
			phase_no++;
		end

		req_valid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		if (error_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	initial begin
		#5000000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
